/* rtl/core/psl_pkg.sv */
// ----------------------------------------------------------------------------
// psl_pkg
// Shared types and constants of the positional sequential list.
// ----------------------------------------------------------------------------
package psl_pkg;

   localparam int DEFAULT_CAPACITY = 128;
   localparam int DATA_W           = 32;
   localparam int POS_W            = 8;
   localparam int CMD_W            = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_GET    = 2'd2,
      CMD_LOCATE = 2'd3
   } cmd_type;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef enum logic [1:0] {
      MODE_HOLD   = 2'd0,
      MODE_ROTATE = 2'd1,
      MODE_INSERT = 2'd2,
      MODE_DELETE = 2'd3
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type     mode;
      logic [POS_W-1:0]  position;
      logic [DATA_W-1:0] value;
   } cell_ctl_type;

endpackage

/* rtl/core/psl_if.sv */
// ----------------------------------------------------------------------------
// psl_if
// Request and response channels of the positional sequential list.
// ----------------------------------------------------------------------------
interface psl_req_if;
   logic                                valid;
   logic                                ready;
   logic [psl_pkg::CMD_W-1:0]           command;
   logic [psl_pkg::POS_W-1:0]           position;
   logic signed [psl_pkg::DATA_W-1:0]   value;

   modport source(output valid, command, position, value, input ready);
   modport sink(input valid, command, position, value, output ready);
endinterface

interface psl_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                status;
   logic signed [psl_pkg::DATA_W-1:0]   element;
   logic [psl_pkg::POS_W-1:0]           found_position;
   logic [psl_pkg::POS_W-1:0]           count;

   modport source(output valid, status, element, found_position, count, input ready);
   modport sink(input valid, status, element, found_position, count, output ready);
endinterface

/* rtl/core/psl_cell.sv */
// ----------------------------------------------------------------------------
// psl_cell
// One list slot: holds an element and takes a neighbour's value or the inserted value on command.
// ----------------------------------------------------------------------------
module psl_cell #(
   parameter int CAPACITY = psl_pkg::DEFAULT_CAPACITY,
   parameter int INDEX    = 0
) (
   input  logic                          clock,
   input  psl_pkg::cell_ctl_type         ctl,
   input  logic [psl_pkg::DATA_W-1:0]    prev_data,
   input  logic [psl_pkg::DATA_W-1:0]    next_data,
   output logic [psl_pkg::DATA_W-1:0]    data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > psl_pkg::POS_W) ? CW : psl_pkg::POS_W;
   localparam logic [PW-1:0] SLOT = PW'(INDEX + 1);

   logic [psl_pkg::DATA_W-1:0] data_ff;
   logic [psl_pkg::DATA_W-1:0] data_in;
   logic [PW-1:0]              pos_ext;

   assign pos_ext = PW'(ctl.position);

   always_comb begin
      data_in = data_ff;
      case (ctl.mode)
         psl_pkg::MODE_HOLD: begin
            data_in = data_ff;
         end
         psl_pkg::MODE_ROTATE: begin
            data_in = next_data;
         end
         psl_pkg::MODE_INSERT: begin
            if (SLOT > pos_ext) begin
               data_in = prev_data;
            end else if (SLOT == pos_ext) begin
               data_in = ctl.value;
            end
         end
         psl_pkg::MODE_DELETE: begin
            if (SLOT >= pos_ext) begin
               data_in = next_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

/* rtl/core/psl_ctrl.sv */
// ----------------------------------------------------------------------------
// psl_ctrl
// Sequencer of the list: checks requests, walks the chain, holds the count.
// ----------------------------------------------------------------------------
module psl_ctrl #(
   parameter int CAPACITY = psl_pkg::DEFAULT_CAPACITY
) (
   input  logic                          clock,
   input  logic                          reset,
   psl_req_if.sink                       req_if,
   psl_rsp_if.source                     rsp_if,
   input  logic [psl_pkg::DATA_W-1:0]    head_data,
   output psl_pkg::cell_ctl_type         ctl
);

   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int PW  = (CW > psl_pkg::POS_W) ? CW : psl_pkg::POS_W;
   localparam int PW1 = PW + 1;
   localparam logic [IW-1:0] LAST_STEP = IW'(CAPACITY - 1);
   localparam logic [CW-1:0] FULL      = CW'(CAPACITY);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type                   state_ff, state_in;
   logic [IW-1:0]               step_ff, step_in;
   psl_pkg::cmd_type            cmd_ff;
   logic [psl_pkg::POS_W-1:0]   pos_ff;
   logic [psl_pkg::DATA_W-1:0]  val_ff;
   logic                        ok_ff;
   logic [psl_pkg::DATA_W-1:0]  elem_ff, elem_in;
   logic                        hit_ff, hit_in;
   logic [psl_pkg::POS_W-1:0]   found_ff, found_in;
   logic [CW-1:0]               fill_ff, fill_in;
   logic                        rsp_valid_ff;
   logic                        rsp_status_ff;
   logic [psl_pkg::DATA_W-1:0]  rsp_element_ff;
   logic [psl_pkg::POS_W-1:0]   rsp_found_ff;
   logic [psl_pkg::POS_W-1:0]   rsp_count_ff;

   logic                        accept;
   logic                        out_free;
   logic                        commit;
   logic [PW1-1:0]              req_pos_ext;
   logic [PW1-1:0]              fill_ext;
   logic [PW1-1:0]              slot_ext;
   logic [PW1-1:0]              fill_out_ext;
   logic                        ins_ok;
   logic                        acc_ok;
   logic                        req_ok;
   psl_pkg::cmd_type            req_cmd;

   assign req_cmd     = psl_pkg::cmd_type'(req_if.command);
   assign accept      = req_if.valid && req_if.ready;
   assign out_free    = !rsp_valid_ff || rsp_if.ready;
   assign commit      = (state_ff == ST_FINISH) && out_free;
   assign req_pos_ext = PW1'(req_if.position);
   assign fill_ext    = PW1'(fill_ff);
   assign slot_ext    = PW1'(step_ff) + PW1'(1);

   assign ins_ok = (fill_ff != FULL) && (req_pos_ext != '0) &&
                   (req_pos_ext <= fill_ext + PW1'(1));
   assign acc_ok = (req_pos_ext != '0) && (req_pos_ext <= fill_ext);

   always_comb begin
      case (req_cmd)
         psl_pkg::CMD_INSERT: req_ok = ins_ok;
         psl_pkg::CMD_DELETE: req_ok = acc_ok;
         psl_pkg::CMD_GET:    req_ok = acc_ok;
         default:             req_ok = 1'b1;
      endcase
   end

   assign req_if.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      elem_in      = elem_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      fill_in      = fill_ff;
      ctl.mode     = psl_pkg::MODE_HOLD;
      ctl.position = pos_ff;
      ctl.value    = val_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               elem_in  = '0;
               hit_in   = 1'b0;
               found_in = '0;
               step_in  = '0;
               if (req_cmd == psl_pkg::CMD_INSERT || !req_ok) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            ctl.mode = psl_pkg::MODE_ROTATE;
            if (cmd_ff == psl_pkg::CMD_LOCATE) begin
               if (!hit_ff && (PW1'(step_ff) < fill_ext) && (head_data == val_ff)) begin
                  hit_in   = 1'b1;
                  found_in = slot_ext[psl_pkg::POS_W-1:0];
               end
            end else if (slot_ext == PW1'(pos_ff)) begin
               elem_in = head_data;
            end
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + IW'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
               if (ok_ff && cmd_ff == psl_pkg::CMD_INSERT) begin
                  ctl.mode = psl_pkg::MODE_INSERT;
                  fill_in  = fill_ff + CW'(1);
               end else if (ok_ff && cmd_ff == psl_pkg::CMD_DELETE) begin
                  ctl.mode = psl_pkg::MODE_DELETE;
                  fill_in  = fill_ff - CW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign fill_out_ext = PW1'(fill_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         fill_ff  <= fill_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      elem_ff  <= elem_in;
      hit_ff   <= hit_in;
      found_ff <= found_in;
      if (accept) begin
         cmd_ff <= req_cmd;
         pos_ff <= req_if.position;
         val_ff <= req_if.value;
         ok_ff  <= req_ok;
      end
      if (commit) begin
         rsp_status_ff  <= ok_ff ? psl_pkg::STATUS_OK : psl_pkg::STATUS_ERR;
         rsp_element_ff <= elem_ff;
         rsp_found_ff   <= found_ff;
         rsp_count_ff   <= fill_out_ext[psl_pkg::POS_W-1:0];
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = rsp_status_ff;
   assign rsp_if.element        = rsp_element_ff;
   assign rsp_if.found_position = rsp_found_ff;
   assign rsp_if.count          = rsp_count_ff;

   a_walk_ends : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && step_ff == LAST_STEP) |=> (state_ff == ST_FINISH))
      else $error("walk did not end after a full rotation");

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL)
      else $error("element count above capacity");

   a_commit_valid : assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("finished request produced no response");

   a_insert_count : assert property (@(posedge clock) disable iff (reset)
      (commit && ok_ff && cmd_ff == psl_pkg::CMD_INSERT) |=>
      (fill_ff == CW'($past(fill_ff) + CW'(1))))
      else $error("successful insert did not raise the count");

   a_idle_step : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (step_ff == '0))
      else $error("step counter not cleared while idle");

endmodule

/* rtl/core/positional_sequential_list_core.sv */
// ----------------------------------------------------------------------------
// positional_sequential_list_core
// Ordered list of signed 32-bit elements with 1-based positions.
// ----------------------------------------------------------------------------
// The list is held in a chain of CAPACITY cells. An insert, or any request
// rejected for a bad position, goes from acceptance straight to the finish
// state, and its response is then registered in the output register, after
// which the controller is idle again: the request is checked on acceptance
// and the chain shifts at commit. Get, a valid delete and locate first make
// one full rotation of the chain past the head cell, where each element is
// examined in turn, before the finish state; a delete then closes the gap at
// commit. A finished request waits in the finish state for as long as the
// previous response is held in the output register. A new request is
// accepted while the previous response still waits in the output register.
// Entries need no clearing after reset; the count, the state, the step
// counter and the response valid flag are reset.
module positional_sequential_list_core #(
   parameter int CAPACITY = psl_pkg::DEFAULT_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   psl_req_if.sink     req_if,
   psl_rsp_if.source   rsp_if
);

   psl_pkg::cell_ctl_type      ctl;
   logic [psl_pkg::DATA_W-1:0] data [CAPACITY];

   psl_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .head_data (data[0]),
      .ctl       (ctl)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam int NXT = (i + 1) % CAPACITY;
      localparam int PRV = (i == 0) ? 0 : i - 1;
      logic [psl_pkg::DATA_W-1:0] prev_data;

      if (i == 0) begin : g_first
         assign prev_data = ctl.value;
      end else begin : g_rest
         assign prev_data = data[PRV];
      end

      psl_cell #(
         .CAPACITY(CAPACITY),
         .INDEX   (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .prev_data (prev_data),
         .next_data (data[NXT]),
         .data      (data[i])
      );
   end

endmodule
